// ===== sv/triangle_normal_and_tangent_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TRIANGLE_NORMAL_AND_TANGENT_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_TANGENT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TNT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define TNT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tnt_pkg.sv =====
package tnt_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               normal_ok;
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic               tangent_ok;
	} res_t;

	// Operations of the shared divide and square-root unit.
	typedef enum logic [0:0] {
		OP_SQRT,
		OP_DIV
	} du_op_t;

	typedef struct packed {
		logic   start;
		du_op_t op;
	} du_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EDGE,
		ST_SCALE,
		ST_CR_MUL,
		ST_CR_SUB,
		ST_CR_NORM,
		ST_SQ_MUL,
		ST_SQ_SUM,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_NDIV_GO,
		ST_NDIV_WAIT,
		ST_DET_MUL,
		ST_DET_SUB,
		ST_NUM_MUL,
		ST_NUM_SUB,
		ST_TDIV_GO,
		ST_TDIV_WAIT,
		ST_OUT
	} st_t;

	localparam int unsigned LIM30_EXP = 30;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Bits needed below the sign of a magnitude: position of the highest set bit plus one.
	function automatic logic [6:0] bitlen(input logic [63:0] m);
		logic [6:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) begin
				r = 7'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/tnt_divsqrt.sv =====
// Shared iterative unit: restoring integer square root (one result bit per cycle)
// or restoring division with saturation (one quotient bit per cycle).
module tnt_divsqrt import tnt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  du_ctl_t      ctl,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	input  logic [6:0]   steps,
	input  logic [32:0]  cap,
	output logic         busy,
	output logic [63:0]  result
);

	logic [63:0]  rem_q;
	logic [63:0]  acc_q;
	logic [63:0]  den_q;
	logic [63:0]  bit_q;
	logic [6:0]   cnt_q;
	logic [32:0]  cap_q;
	logic         sat_q;
	du_op_t       op_q;
	logic         busy_q;

	logic [64:0]  rem_sh;
	logic [64:0]  qn;
	logic [63:0]  trial;

	// For a division, bit_q holds the dividend and feeds it in from the top, one bit a
	// cycle; once all 64 dividend bits are fed in it is empty and the remaining steps give fraction bits.
	always_comb begin
		rem_sh = {rem_q, bit_q[63]};
		trial  = acc_q + bit_q;
		qn     = {acc_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (ctl.op == OP_SQRT) ? 7'd32 : 7'(7'd64 + steps);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q  <= ctl.op;
			cap_q <= cap;
			den_q <= b;
			sat_q <= 1'b0;
			if (ctl.op == OP_SQRT) begin
				rem_q <= a;
				acc_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end else begin
				rem_q <= '0;
				acc_q <= '0;
				bit_q <= a;
			end
		end else if (busy_q && cnt_q != '0) begin
			unique case (op_q)
				OP_SQRT: begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						acc_q <= (acc_q >> 1) + bit_q;
					end else begin
						acc_q <= acc_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				OP_DIV: begin
					bit_q <= bit_q << 1;
					// The partial quotient only grows, so once past the cap it stays there.
					if (!sat_q) begin
						if (rem_sh >= 65'(den_q)) begin
							rem_q <= 64'(rem_sh - 65'(den_q));
							acc_q <= 64'(qn) | 64'd1;
							sat_q <= ((qn | 65'd1) > 65'(cap_q));
						end else begin
							rem_q <= 64'(rem_sh);
							acc_q <= 64'(qn);
							sat_q <= (qn > 65'(cap_q));
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = busy_q || ctl.start;
	assign result = (op_q == OP_DIV && sat_q) ? 64'(cap_q) : acc_q;

endmodule

// ===== sv/triangle_normal_and_tangent.sv =====
// Channel | Direction | Handshake          | Payload
// vtx     | in        | vtx_valid/vtx_stall | vtx_t, one mesh corner
// res     | out       | res_valid/res_stall | res_t, one result per triangle
// Corners one and two are registered as they are taken. The third corner starts the
// sequencer, whose run time is set by the shared square-root and divider unit: a
// 32-step square root, three 64-step normal divides and three tangent divides of
// 64 + FRAC_BITS + bsh_q - ash_q steps. Degenerate faces skip divides.
// Reset clears the corner count, sets uv_q to 1, and empties the output register.
// While the sequencer runs, or a result waits on res_stall, vtx_stall is high.
module triangle_normal_and_tangent import tnt_pkg::*; #(
	parameter int FRAC_BITS        = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic vtx_valid,
	output logic vtx_stall,
	input  vtx_t vtx,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	st_t st_q, st_nx;
	logic uv_q;
	logic [1:0] corner_q;
	logic signed [31:0] hp_q [6];
	logic signed [31:0] ht_q [4];
	logic signed [31:0] p2_q [3];
	logic signed [31:0] t2_q [2];

	logic signed [63:0] ea_q [3];
	logic signed [63:0] eb_q [3];
	logic signed [63:0] qq_q [6];
	logic signed [63:0] dd_q [4];
	logic [6:0] bsh_q, ash_q;
	logic signed [63:0] pr_q [6];
	logic signed [63:0] c_q [3];
	logic [63:0] sum_q, len_q;
	logic signed [63:0] det_q, num_q;
	logic [1:0] idx_q;
	logic signed [15:0] n_q [3];
	logic signed [31:0] t_q [3];
	logic nok_q, tok_q;
	logic res_valid_q;
	res_t res_q;

	logic accept;
	logic signed [31:0] u_in, v_in;
	logic signed [32:0] vflip;

	du_ctl_t du_ctl;
	logic [63:0] du_a, du_b, du_res;
	logic [6:0] du_steps;
	logic [32:0] du_cap;
	logic du_busy;

	tnt_divsqrt u_du (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (du_ctl),
		.a      (du_a),
		.b      (du_b),
		.steps  (du_steps),
		.cap    (du_cap),
		.busy   (du_busy),
		.result (du_res)
	);

	assign accept    = vtx_valid && !vtx_stall;
	assign vtx_stall = (st_q != ST_IDLE) || (res_valid_q && res_stall);

	always_comb begin
		vflip = 33'sd1 <<< FRAC_BITS;
		vflip = vflip - 33'(vtx.tex_v);
		if (!uv_q) begin
			u_in = '0;
			v_in = '0;
		end else begin
			u_in = vtx.tex_u;
			if (vflip > 33'sh0_7fff_ffff) begin
				v_in = 32'sh7fff_ffff;
			end else begin
				v_in = vflip[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_q <= 1'b1;
		end else if (cfg_we) begin
			uv_q <= cfg_wdata;
		end
	end

	// Shift amount to bring magnitude m below 2^30.
	function automatic logic [6:0] over30(input logic [63:0] m);
		logic [6:0] l;
		l = bitlen(m);
		return (l > 7'(LIM30_EXP)) ? 7'(l - 7'(LIM30_EXP)) : 7'd0;
	endfunction

	function automatic logic signed [63:0] shr_mag(input logic signed [63:0] v,
		input logic [6:0] s);
		logic [63:0] m;
		m = mag64(v) >> s;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] shl_mag(input logic signed [63:0] v,
		input logic [6:0] s);
		logic [63:0] m;
		m = mag64(v) << s;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	// All operands are scaled below 2^30 before they are multiplied.
	function automatic logic signed [63:0] mul32(input logic signed [31:0] x,
		input logic signed [31:0] y);
		return x * y;
	endfunction

	logic [63:0] mx_a, mx_b, mx_q, mx_d, mx_c;
	logic [6:0] cl;
	always_comb begin
		mx_a = '0; mx_b = '0; mx_q = '0; mx_d = '0; mx_c = '0;
		for (int i = 0; i < 3; i++) begin
			mx_a = mx_a | mag64(ea_q[i]);
			mx_b = mx_b | mag64(eb_q[i]);
			mx_c = mx_c | mag64(c_q[i]);
		end
		for (int i = 0; i < 6; i++) begin
			mx_q = mx_q | mag64(qq_q[i]);
		end
		for (int i = 0; i < 4; i++) begin
			mx_d = mx_d | mag64(dd_q[i]);
		end
		cl = bitlen(mx_c);
	end

	// Next-state logic.
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE:      st_nx = (accept && corner_q == 2'd2) ? ST_EDGE : ST_IDLE;
			ST_EDGE:      st_nx = ST_SCALE;
			ST_SCALE:     st_nx = ST_CR_MUL;
			ST_CR_MUL:    st_nx = ST_CR_SUB;
			ST_CR_SUB:    st_nx = ST_CR_NORM;
			ST_CR_NORM:   st_nx = (mx_c == '0) ? ST_DET_MUL : ST_SQ_MUL;
			ST_SQ_MUL:    st_nx = ST_SQ_SUM;
			ST_SQ_SUM:    st_nx = ST_SQRT_GO;
			ST_SQRT_GO:   st_nx = ST_SQRT_WAIT;
			ST_SQRT_WAIT: st_nx = du_busy ? ST_SQRT_WAIT : ST_NDIV_GO;
			ST_NDIV_GO:   st_nx = ST_NDIV_WAIT;
			ST_NDIV_WAIT: st_nx = du_busy ? ST_NDIV_WAIT :
				((idx_q == 2'd2) ? ST_DET_MUL : ST_NDIV_GO);
			ST_DET_MUL:   st_nx = ST_DET_SUB;
			ST_DET_SUB:   st_nx = ST_NUM_MUL;
			ST_NUM_MUL:   st_nx = (det_q == '0) ? ST_OUT : ST_NUM_SUB;
			ST_NUM_SUB:   st_nx = ST_TDIV_GO;
			ST_TDIV_GO:   st_nx = ST_TDIV_WAIT;
			ST_TDIV_WAIT: st_nx = du_busy ? ST_TDIV_WAIT :
				((idx_q == 2'd2) ? ST_OUT : ST_NUM_MUL);
			ST_OUT:       st_nx = (res_valid_q && res_stall) ? ST_OUT : ST_IDLE;
			default:      st_nx = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer towards the shared unit.
	logic [63:0] nmag, tnum, tden;
	logic [6:0]  texp;
	always_comb begin
		du_ctl.start = 1'b0;
		du_ctl.op    = OP_SQRT;
		du_a = sum_q;
		du_b = 64'd1;
		du_steps = '0;
		du_cap = 33'h0_7fff_ffff;
		nmag = mag64(c_q[idx_q]) << NORMAL_FRAC_BITS;
		tnum = mag64(num_q);
		tden = mag64(det_q);
		texp = 7'(7'(FRAC_BITS) + bsh_q - ash_q);
		unique case (st_q)
			ST_SQRT_GO: begin
				du_ctl.start = 1'b1;
			end
			ST_NDIV_GO: begin
				du_ctl.start = 1'b1;
				du_ctl.op    = OP_DIV;
				du_a = nmag + (len_q >> 1);
				du_b = len_q;
				du_cap = 33'h1_ffff_ffff;
			end
			ST_TDIV_GO: begin
				du_ctl.start = 1'b1;
				du_ctl.op    = OP_DIV;
				du_a = tnum;
				du_b = tden;
				du_steps = texp;
				du_cap = (num_q[63] != det_q[63] && num_q != '0) ?
					33'h0_8000_0000 : 33'h0_7fff_ffff;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			corner_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (accept) begin
				corner_q <= (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
			end
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (st_q == ST_OUT && !(res_valid_q && res_stall)) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (corner_q == 2'd0) begin
				hp_q[0] <= vtx.pos_x; hp_q[1] <= vtx.pos_y; hp_q[2] <= vtx.pos_z;
				ht_q[0] <= u_in; ht_q[1] <= v_in;
			end else if (corner_q == 2'd1) begin
				hp_q[3] <= vtx.pos_x; hp_q[4] <= vtx.pos_y; hp_q[5] <= vtx.pos_z;
				ht_q[2] <= u_in; ht_q[3] <= v_in;
			end else begin
				p2_q[0] <= vtx.pos_x; p2_q[1] <= vtx.pos_y; p2_q[2] <= vtx.pos_z;
				t2_q[0] <= u_in; t2_q[1] <= v_in;
			end
		end
		unique case (st_q)
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					ea_q[i] <= 64'(hp_q[3 + i]) - 64'(hp_q[i]);
					eb_q[i] <= 64'(p2_q[i]) - 64'(hp_q[i]);
					qq_q[i] <= 64'(hp_q[3 + i]) - 64'(hp_q[i]);
					qq_q[3 + i] <= 64'(p2_q[i]) - 64'(hp_q[i]);
				end
				dd_q[0] <= 64'(ht_q[2]) - 64'(ht_q[0]);
				dd_q[1] <= 64'(ht_q[3]) - 64'(ht_q[1]);
				dd_q[2] <= 64'(t2_q[0]) - 64'(ht_q[0]);
				dd_q[3] <= 64'(t2_q[1]) - 64'(ht_q[1]);
				nok_q <= 1'b0;
				tok_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					n_q[i] <= '0;
					t_q[i] <= '0;
				end
			end
			ST_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					ea_q[i] <= shr_mag(ea_q[i], over30(mx_a));
					eb_q[i] <= shr_mag(eb_q[i], over30(mx_b));
				end
				for (int i = 0; i < 6; i++) begin
					qq_q[i] <= shr_mag(qq_q[i], over30(mx_q));
				end
				for (int i = 0; i < 4; i++) begin
					dd_q[i] <= shr_mag(dd_q[i], over30(mx_d));
				end
				bsh_q <= over30(mx_q);
				ash_q <= over30(mx_d);
			end
			ST_CR_MUL: begin
				pr_q[0] <= mul32(32'(ea_q[1]), 32'(eb_q[2]));
				pr_q[1] <= mul32(32'(ea_q[2]), 32'(eb_q[1]));
				pr_q[2] <= mul32(32'(ea_q[2]), 32'(eb_q[0]));
				pr_q[3] <= mul32(32'(ea_q[0]), 32'(eb_q[2]));
				pr_q[4] <= mul32(32'(ea_q[0]), 32'(eb_q[1]));
				pr_q[5] <= mul32(32'(ea_q[1]), 32'(eb_q[0]));
			end
			ST_CR_SUB: begin
				c_q[0] <= pr_q[0] - pr_q[1];
				c_q[1] <= pr_q[2] - pr_q[3];
				c_q[2] <= pr_q[4] - pr_q[5];
			end
			ST_CR_NORM: begin
				for (int i = 0; i < 3; i++) begin
					if (cl > 7'd30) begin
						c_q[i] <= shr_mag(c_q[i], 7'(cl - 7'd30));
					end else if (cl != '0) begin
						c_q[i] <= shl_mag(c_q[i], 7'(7'd30 - cl));
					end
				end
			end
			ST_SQ_MUL: begin
				for (int i = 0; i < 3; i++) begin
					pr_q[i] <= mul32(32'(c_q[i]), 32'(c_q[i]));
				end
			end
			ST_SQ_SUM: begin
				sum_q <= 64'(pr_q[0]) + 64'(pr_q[1]) + 64'(pr_q[2]);
				idx_q <= '0;
			end
			ST_SQRT_WAIT: begin
				if (!du_busy) begin
					len_q <= du_res;
					nok_q <= 1'b1;
				end
			end
			ST_NDIV_WAIT: begin
				if (!du_busy) begin
					if (c_q[idx_q][63]) begin
						n_q[idx_q] <= (du_res > 64'd32768) ? -16'sd32768 :
							-$signed(16'(du_res));
					end else begin
						n_q[idx_q] <= (du_res > 64'd32767) ? 16'sd32767 :
							$signed(16'(du_res));
					end
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
			end
			ST_DET_MUL: begin
				pr_q[0] <= mul32(32'(dd_q[0]), 32'(dd_q[3]));
				pr_q[1] <= mul32(32'(dd_q[1]), 32'(dd_q[2]));
				idx_q <= '0;
			end
			ST_DET_SUB: begin
				det_q <= pr_q[0] - pr_q[1];
			end
			ST_NUM_MUL: begin
				tok_q <= (det_q != '0);
				pr_q[2] <= mul32(32'(qq_q[idx_q]), 32'(dd_q[3]));
				pr_q[3] <= mul32(32'(qq_q[3 + idx_q]), 32'(dd_q[1]));
			end
			ST_NUM_SUB: begin
				num_q <= pr_q[2] - pr_q[3];
			end
			ST_TDIV_WAIT: begin
				if (!du_busy) begin
					if (num_q[63] != det_q[63] && num_q != '0) begin
						t_q[idx_q] <= -$signed(32'(du_res));
					end else begin
						t_q[idx_q] <= $signed(32'(du_res));
					end
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
			end
			ST_OUT: begin
				if (!(res_valid_q && res_stall)) begin
					res_q.normal_x   <= n_q[0];
					res_q.normal_y   <= n_q[1];
					res_q.normal_z   <= n_q[2];
					res_q.normal_ok  <= nok_q;
					res_q.tangent_x  <= t_q[0];
					res_q.tangent_y  <= t_q[1];
					res_q.tangent_z  <= t_q[2];
					res_q.tangent_ok <= tok_q;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== sv/tnt_checker.sv =====
module tnt_checker import tnt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic vtx_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

`include "triangle_normal_and_tangent_assert.svh"

	`TNT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
	`TNT_ASSERT_IMP(a_nok_zero, clk, arst_n, res_valid && !res.normal_ok, res.normal_x == 16'sd0 && res.normal_y == 16'sd0 && res.normal_z == 16'sd0, "zero normal not zero")
	`TNT_ASSERT_IMP(a_tok_zero, clk, arst_n, res_valid && !res.tangent_ok, res.tangent_x == 32'sd0 && res.tangent_y == 32'sd0 && res.tangent_z == 32'sd0, "zero tangent not zero")
	`TNT_ASSERT_IMP(a_busy_stall, clk, arst_n, res_valid && res_stall, vtx_stall, "input taken while result waits")

endmodule

bind triangle_normal_and_tangent tnt_checker u_tnt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vtx_stall (vtx_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import tnt_pkg::*;

	localparam int FRAC = 16;
	localparam int NFRAC = 14;
	localparam longint unsigned LIM30 = 64'd1 << 30;
	localparam longint unsigned LIM29 = 64'd1 << 29;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic vtx_valid;
	logic vtx_stall;
	vtx_t vtx;
	logic res_valid;
	logic res_stall;
	res_t res;

	int error_count = 0;
	bit calm = 0;

	triangle_normal_and_tangent i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic longint unsigned mag(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Shifts a group right on magnitudes until all lie below 2^30.
	function automatic int scale_group(inout longint g[6], input int n);
		longint unsigned m;
		int s;
		m = 0;
		s = 0;
		for (int i = 0; i < n; i++) if (mag(g[i]) > m) m = mag(g[i]);
		while ((m >> s) >= LIM30) s++;
		for (int i = 0; i < n; i++)
			g[i] = g[i] < 0 ? -longint'(mag(g[i]) >> s) : longint'(mag(g[i]) >> s);
		return s;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint tangent_div(input longint num, input longint den, input int e);
		longint unsigned un, ud, q, r, cap;
		bit neg;
		un = mag(num);
		ud = mag(den);
		neg = ((num < 0) != (den < 0)) && un != 0;
		cap = neg ? 64'd1 << 31 : (64'd1 << 31) - 1;
		q = un / ud;
		r = un % ud;
		if (q > cap) return neg ? -longint'(cap) : longint'(cap);
		for (int i = 0; i < e; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= ud) begin
				r -= ud;
				q |= 1;
			end
			if (q > cap) return neg ? -longint'(cap) : longint'(cap);
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	class face_scoreboard;
		bit uv_on = 1;
		longint corner_pos[6];
		longint corner_tex[4];
		int corner_count = 0;
		res_t pending[$];

		function void note_vertex(vtx_t item);
			longint p[3], u, v, a[6], b[6], c[6], q[6], d[6], det, num;
			longint unsigned m, sum, len, t;
			int sh, bq, ad;
			res_t r;
			p[0] = item.pos_x;
			p[1] = item.pos_y;
			p[2] = item.pos_z;
			u = uv_on ? longint'(item.tex_u) : 0;
			v = uv_on ? sat32((64'sd1 <<< FRAC) - longint'(item.tex_v)) : 0;
			if (corner_count < 2) begin
				for (int i = 0; i < 3; i++) corner_pos[corner_count * 3 + i] = p[i];
				corner_tex[corner_count * 2] = u;
				corner_tex[corner_count * 2 + 1] = v;
				corner_count++;
				return;
			end
			corner_count = 0;
			r = '0;
			for (int i = 0; i < 3; i++) begin
				a[i] = corner_pos[3 + i] - corner_pos[i];
				b[i] = p[i] - corner_pos[i];
				q[i] = a[i];
				q[3 + i] = b[i];
			end
			void'(scale_group(a, 3));
			void'(scale_group(b, 3));
			c[0] = a[1] * b[2] - a[2] * b[1];
			c[1] = a[2] * b[0] - a[0] * b[2];
			c[2] = a[0] * b[1] - a[1] * b[0];
			m = 0;
			for (int i = 0; i < 3; i++) if (mag(c[i]) > m) m = mag(c[i]);
			if (m != 0) begin
				if (m >= LIM30) begin
					void'(scale_group(c, 3));
				end else begin
					sh = 0;
					while ((m << sh) < LIM29) sh++;
					for (int i = 0; i < 3; i++) c[i] = c[i] <<< sh;
				end
				sum = 0;
				for (int i = 0; i < 3; i++) sum += mag(c[i]) * mag(c[i]);
				len = int_sqrt(sum);
				for (int i = 0; i < 3; i++) begin
					t = ((mag(c[i]) << NFRAC) + len / 2) / len;
					if (c[i] < 0) t = t > 32768 ? -64'sd32768 : -longint'(t);
					else if (t > 32767) t = 32767;
					case (i)
						0: r.normal_x = t[15:0];
						1: r.normal_y = t[15:0];
						default: r.normal_z = t[15:0];
					endcase
				end
				r.normal_ok = 1;
			end
			bq = scale_group(q, 6);
			d[0] = corner_tex[2] - corner_tex[0];
			d[1] = corner_tex[3] - corner_tex[1];
			d[2] = u - corner_tex[0];
			d[3] = v - corner_tex[1];
			ad = scale_group(d, 4);
			det = d[0] * d[3] - d[1] * d[2];
			if (det != 0) begin
				r.tangent_ok = 1;
				for (int i = 0; i < 3; i++) begin
					num = q[i] * d[3] - q[3 + i] * d[1];
					t = tangent_div(num, det, FRAC + bq - ad);
					case (i)
						0: r.tangent_x = t[31:0];
						1: r.tangent_y = t[31:0];
						default: r.tangent_z = t[31:0];
					endcase
				end
			end
			pending = {pending, r};
		endfunction

		task check_face(res_t got);
			res_t w;
			if (pending.size() == 0) begin
				report("unexpected item", 1, 0);
				return;
			end
			w = pending.pop_front();
			if (got.normal_x !== w.normal_x) report("normal_x", got.normal_x, w.normal_x);
			if (got.normal_y !== w.normal_y) report("normal_y", got.normal_y, w.normal_y);
			if (got.normal_z !== w.normal_z) report("normal_z", got.normal_z, w.normal_z);
			if (got.normal_ok !== w.normal_ok) report("normal_ok", got.normal_ok, w.normal_ok);
			if (got.tangent_x !== w.tangent_x) report("tangent_x", got.tangent_x, w.tangent_x);
			if (got.tangent_y !== w.tangent_y) report("tangent_y", got.tangent_y, w.tangent_y);
			if (got.tangent_z !== w.tangent_z) report("tangent_z", got.tangent_z, w.tangent_z);
			if (got.tangent_ok !== w.tangent_ok)
				report("tangent_ok", got.tangent_ok, w.tangent_ok);
		endtask
	endclass

	face_scoreboard faces = new();

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) faces.check_face(res);
	end

	always @(negedge clk) begin
		res_stall <= !calm && $urandom_range(99) < 16;
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
			3: return 32'($signed($urandom_range(20)) - 10) <<< 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_vertex(input vtx_t item);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 16) begin
			vtx_valid <= 0;
			@(negedge clk);
		end
		vtx_valid <= 1;
		vtx <= item;
		@(posedge clk);
		while (vtx_stall) @(posedge clk);
		faces.note_vertex(item);
		@(negedge clk);
		vtx_valid <= 0;
	endtask

	task automatic send_corner(input logic [31:0] x, y, z, u, v);
		vtx_t item;
		item.pos_x = x;
		item.pos_y = y;
		item.pos_z = z;
		item.tex_u = u;
		item.tex_v = v;
		send_vertex(item);
	endtask

	task automatic set_uv(input bit on);
		int waited;
		waited = 0;
		while (faces.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= on;
		@(negedge clk);
		cfg_we <= 0;
		faces.uv_on = on;
	endtask

	task automatic send_random_face();
		vtx_t item;
		for (int k = 0; k < 3; k++) begin
			item.pos_x = rand_word();
			item.pos_y = rand_word();
			item.pos_z = rand_word();
			item.tex_u = rand_word();
			item.tex_v = rand_word();
			send_vertex(item);
		end
	endtask

	initial begin
		int waited;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		vtx_valid = 0;
		vtx = '0;
		res_stall = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed faces: a plain right triangle, a degenerate one with
		// repeated corners, collinear corners, the extremes of the range and two more faces.
		send_corner(0, 0, 0, 0, 0);
		send_corner(32'h10000, 0, 0, 32'h10000, 0);
		send_corner(0, 32'h10000, 0, 0, 32'h10000);
		send_corner(5, 5, 5, 7, 7);
		send_corner(5, 5, 5, 7, 7);
		send_corner(5, 5, 5, 7, 7);
		send_corner(0, 0, 0, 0, 0);
		send_corner(32'h10000, 32'h10000, 32'h10000, 1, 2);
		send_corner(32'h20000, 32'h20000, 32'h20000, 3, 9);
		send_corner(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_corner(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_corner(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_corner(0, 0, 0, 0, 0);
		send_corner(32'hffff_ffff, 1, 0, 1, 32'h1_0000);
		send_corner(0, 0, 1, 32'h8000_0000, 32'h0001_0001);
		set_uv(0);
		send_corner(0, 0, 0, 3, 4);
		send_corner(32'h10000, 0, 0, 5, 6);
		send_corner(0, 0, 32'h10000, 7, 8);
		set_uv(1);

		for (int n = 0; n < 480; n++) begin
			calm = (n >= 200 && n < 260);
			if (n == 150) set_uv(0);
			if (n == 180) set_uv(1);
			if (n == 400) set_uv(0);
			if (n == 420) set_uv(1);
			send_random_face();
		end
		calm = 0;

		waited = 0;
		while (faces.pending.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (400) @(posedge clk);
		if (error_count == 0 && faces.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== triangle_normal_and_tangent.f =====
+incdir+sv
sv/tnt_pkg.sv
sv/tnt_divsqrt.sv
sv/triangle_normal_and_tangent.sv
sv/tnt_checker.sv
sim/testbench.sv
